/* hw/rtl/ams_pkg.sv */
// Shared types, sizes and instruction codes for the accumulator machine core.
// No dependencies; imported by every module of the block.
`default_nettype none

package ams_pkg;

	localparam int DATA_DEPTH = 1024;
	localparam int PROG_DEPTH = 1024;
	localparam int WORD_BITS  = 32;
	localparam int ADDR_BITS  = $clog2(DATA_DEPTH);
	localparam int PC_BITS    = $clog2(PROG_DEPTH + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [PC_BITS-1:0]   pc_t;

	// item kinds
	localparam logic [1:0] OPR_EXEC  = 2'd0;
	localparam logic [1:0] OPR_WRITE = 2'd1;
	localparam logic [1:0] OPR_READ  = 2'd2;

	// instruction set
	localparam logic [3:0] OPC_LDA = 4'd0;
	localparam logic [3:0] OPC_LDI = 4'd1;
	localparam logic [3:0] OPC_STA = 4'd2;
	localparam logic [3:0] OPC_STI = 4'd3;
	localparam logic [3:0] OPC_ADD = 4'd4;
	localparam logic [3:0] OPC_SUB = 4'd5;
	localparam logic [3:0] OPC_JMP = 4'd6;
	localparam logic [3:0] OPC_JMZ = 4'd7;
	localparam logic [3:0] OPC_JMN = 4'd8;
	localparam logic [3:0] OPC_HLT = 4'd9;

	// single data memory port request
	typedef struct packed {
		logic  we;
		addr_t addr;
		word_t wdata;
	} mem_req_t;

	// accumulator tests from the arithmetic unit
	typedef struct packed {
		logic zero;
		logic neg;
	} alu_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/ams_mem.sv */
// Single-port data memory with registered read data, no reset on contents.
// Depends on ams_pkg.
`default_nettype none

module ams_mem (
	input  wire               clk,
	input  wire ams_pkg::mem_req_t req,
	output ams_pkg::word_t    rdata
);
	import ams_pkg::*;

	word_t mem_q [DATA_DEPTH];
	word_t rdata_q;

	// one access per cycle at req.addr: an optional write, and a read of the old contents
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		rdata_q <= mem_q[req.addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/ams_alu.sv */
// Shared add/subtract unit and accumulator tests (zero, negative).
// Depends on ams_pkg.
`default_nettype none

module ams_alu (
	input  wire ams_pkg::word_t a,
	input  wire ams_pkg::word_t b,
	input  wire                 sub,
	output ams_pkg::word_t      result,
	output ams_pkg::alu_flags_t flags
);
	import ams_pkg::*;

	// wraps to the word width
	assign result     = sub ? (a - b) : (a + b);
	assign flags.zero = (a == '0);
	assign flags.neg  = a[WORD_BITS-1];

endmodule

`default_nettype wire

/* hw/rtl/accumulator_machine_step.sv */
// Top level of the accumulator machine core: sequencer, machine state, ports.
// Depends on ams_pkg, ams_mem, ams_alu.
//
//  chan | handshake           | fields
//  in   | in_valid/in_ready   | operation, opcode, operand, data_value
//  out  | out_valid/out_ready | next_pc, accumulator_value, halted, illegal_opcode, read_value
//  cfg  | cfg_valid/cfg_ready | cfg_data (program length), ready only while idle
//
// A request passes through the accept, decode and result states when it needs no data
// word; a memory read (LDA, ADD, SUB, read request) adds an execute state, an indirect
// store (STI) a pointer state, and an indirect load (LDI) both: pointer read, then data
// read, all through the one memory port. in_ready is low from acceptance until the
// result is taken; a stalled result holds until out_ready. Reset clears pc, accumulator
// and flags and sets the length to 1024; memory contents are not cleared.
`default_nettype none

module accumulator_machine_step (
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire ams_pkg::pc_t     cfg_data,
	// requests
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [1:0]            operation,
	input  wire  [3:0]            opcode,
	input  wire ams_pkg::addr_t   operand,
	input  wire signed [ams_pkg::WORD_BITS-1:0] data_value,
	// results
	output logic                  out_valid,
	input  wire                   out_ready,
	output ams_pkg::pc_t          next_pc,
	output logic signed [ams_pkg::WORD_BITS-1:0] accumulator_value,
	output logic                  halted,
	output logic                  illegal_opcode,
	output logic signed [ams_pkg::WORD_BITS-1:0] read_value
);
	import ams_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_PTR    = 3'd2;
	localparam logic [2:0] ST_EXEC   = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0] state_q;
	pc_t        pc_q;
	pc_t        len_q;
	word_t      acc_q;
	word_t      rval_q;
	logic       halt_q;
	logic       ill_q;

	// captured request
	logic [1:0] operation_q;
	logic [3:0] opcode_q;
	addr_t      operand_q;
	word_t      data_q;

	mem_req_t   mem_req;
	word_t      mem_rdata;
	word_t      alu_result;
	alu_flags_t alu_flags;

	pc_t        len_eff;
	pc_t        pc_new;
	logic       exec_ok;

	ams_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	ams_alu u_alu (
		.a      (acc_q),
		.b      (mem_rdata),
		.sub    (opcode_q == OPC_SUB),
		.result (alu_result),
		.flags  (alu_flags)
	);

	// program length saturates at the program depth
	assign len_eff = (len_q > pc_t'(PROG_DEPTH)) ? pc_t'(PROG_DEPTH) : len_q;
	assign exec_ok = (operation_q == OPR_EXEC) && !halt_q && (pc_q < len_eff);

	// next pc for a completed instruction (jumps or fall-through)
	always_comb begin
		pc_new = pc_q + pc_t'(1);
		unique case (opcode_q)
			OPC_JMP: pc_new = pc_t'(operand_q);
			OPC_JMZ: if (alu_flags.zero) pc_new = pc_t'(operand_q);
			OPC_JMN: if (alu_flags.neg) pc_new = pc_t'(operand_q);
			default: ;
		endcase
	end

	// memory port steering
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = operand_q;
		mem_req.wdata = acc_q;
		unique case (state_q)
			ST_DECODE: begin
				if (operation_q == OPR_WRITE) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = data_q;
				end else if (exec_ok && opcode_q == OPC_STA) begin
					mem_req.we = 1'b1;
				end
			end
			ST_PTR: begin
				mem_req.addr = mem_rdata[ADDR_BITS-1:0];
				mem_req.we   = (opcode_q == OPC_STI);
			end
			default: ;
		endcase
	end

	// sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			acc_q   <= '0;
			halt_q  <= 1'b0;
			ill_q   <= 1'b0;
			len_q   <= pc_t'(PROG_DEPTH);
			rval_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					rval_q <= '0;
					if (operation_q == OPR_READ) begin
						state_q <= ST_EXEC;
					end else if (operation_q == OPR_EXEC && !halt_q) begin
						if (pc_q >= len_eff) begin
							halt_q  <= 1'b1;
							state_q <= ST_RESP;
						end else begin
							unique case (opcode_q)
								OPC_LDA, OPC_ADD, OPC_SUB: state_q <= ST_EXEC;
								OPC_LDI, OPC_STI:          state_q <= ST_PTR;
								OPC_STA, OPC_JMP, OPC_JMZ, OPC_JMN: begin
									pc_q    <= pc_new;
									if (pc_new >= len_eff) halt_q <= 1'b1;
									state_q <= ST_RESP;
								end
								OPC_HLT: begin
									pc_q    <= len_eff;
									halt_q  <= 1'b1;
									state_q <= ST_RESP;
								end
								default: begin
									halt_q  <= 1'b1;
									ill_q   <= 1'b1;
									state_q <= ST_RESP;
								end
							endcase
						end
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_PTR: begin
					if (opcode_q == OPC_STI) begin
						pc_q    <= pc_new;
						if (pc_new >= len_eff) halt_q <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
					if (operation_q == OPR_READ) begin
						rval_q <= mem_rdata;
					end else begin
						if (opcode_q == OPC_ADD || opcode_q == OPC_SUB) begin
							acc_q <= alu_result;
						end else begin
							acc_q <= mem_rdata;
						end
						pc_q <= pc_new;
						if (pc_new >= len_eff) halt_q <= 1'b1;
					end
				end
				ST_RESP: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_q <= operation;
			opcode_q    <= opcode;
			operand_q   <= operand;
			data_q      <= data_value;
		end
	end

	// length changes only between requests
	assign cfg_ready         = (state_q == ST_IDLE);
	assign in_ready          = (state_q == ST_IDLE);
	assign out_valid         = (state_q == ST_RESP);
	assign next_pc           = pc_q;
	assign accumulator_value = acc_q;
	assign halted            = halt_q;
	assign illegal_opcode    = ill_q;
	assign read_value        = rval_q;

	// checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request accepted while a result is pending");

	a_ill_halts: assert property (@(posedge clk) disable iff (!arst_n)
		ill_q |-> halt_q)
		else $error("illegal flag set without halt");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(halt_q))
		else $error("halt cleared outside reset");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= pc_t'(PROG_DEPTH))
		else $error("pc beyond program depth");

endmodule

`default_nettype wire
